// ===== hdl/bitmap_block_allocator_core_assert.svh =====
// assertion macros shared by the allocator rtl
// depends on nothing; users include it inside a module that has clk_i and rst_ni
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bba assertion failed");
`define BBA_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define BBA_ASSERT(label, prop)
`define BBA_ASSERT_MSG(label, prop, msg)
`endif
`endif

// ===== hdl/bba_pkg.sv =====
// shared types, constants and helpers of the bitmap block allocator
// no dependencies
package bba_pkg;

  localparam int MapBits  = 4096;
  localparam int WordBits = 32;
  localparam int MapWords = MapBits / WordBits;
  localparam int AddrW    = $clog2(MapWords);
  localparam int BitW     = $clog2(WordBits);
  localparam int IdxW     = $clog2(MapBits);
  localparam int BlkW     = 12;
  localparam int TotW     = 13;

  localparam logic [TotW-1:0] TotalReset = TotW'(4096);
  // blocks 0 and 1 always count as used during a find
  localparam logic [WordBits-1:0] ReservedMask = WordBits'(2'b11);

  typedef enum logic [1:0] {
    ActFind = 2'd0,
    ActUse  = 2'd1,
    ActFree = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [BlkW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [BlkW-1:0] found_index;
    logic            status;
    logic            bit_changed;
  } rsp_t;

  typedef struct packed {
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [WordBits-1:0] wr_data;
  } map_req_t;

  // position of the lowest clear bit; only meaningful when one exists
  function automatic logic [BitW-1:0] lowest_zero(logic [WordBits-1:0] w);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BitW'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hdl/bitmap_block_allocator_core.sv =====
// first-fit bitmap block allocator, one word in flight at a time
// find: scans the words upward from word 0; the result strobe comes with the first
//   word that holds a clear bit, or after the last of the 128 words
// mark: read, then write-back in StMark; unused action: no map access
// busy drops as the result is shown, so the next request can be taken with it
// reset clears the map through per-word valid bits at once, no clearing pass
`include "bitmap_block_allocator_core_assert.svh"
module bitmap_block_allocator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bba_pkg::req_t             req_i,
  output logic                      rsp_valid_o,
  output bba_pkg::rsp_t             rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bba_pkg::TotW-1:0]  cfg_data_i
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StMark
  } state_e;

  state_e              state_q;
  logic [AddrW-1:0]    addr_q;
  req_t                req_q;
  logic [TotW-1:0]     total_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;

  map_req_t            map_req;
  logic [WordBits-1:0] rd_word;
  logic [WordBits-1:0] scan_word;
  logic [BitW-1:0]     zero_pos;
  logic [IdxW-1:0]     found_full;
  logic                scan_hit;
  logic                scan_last;
  logic [BitW-1:0]     mark_pos;
  logic [AddrW-1:0]    mark_addr;
  logic                mark_in_range;
  logic                mark_want;
  logic                mark_change;
  logic [WordBits-1:0] mark_mask;
  logic                accept;

  bba_map u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (map_req),
    .rd_word_o(rd_word)
  );

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  // scan datapath
  assign scan_word  = rd_word | ((addr_q == '0) ? ReservedMask : '0);
  assign scan_hit   = ~&scan_word;
  assign scan_last  = (addr_q == AddrW'(MapWords - 1));
  assign zero_pos   = lowest_zero(scan_word);
  assign found_full = IdxW'({addr_q, zero_pos});

  // mark datapath
  assign mark_pos      = req_q.block_index[BitW-1:0];
  assign mark_addr     = AddrW'(req_q.block_index >> BitW);
  assign mark_in_range = (32'(req_q.block_index) < MapBits);
  assign mark_want     = (req_q.action == ActUse);
  assign mark_mask     = WordBits'(1) << mark_pos;
  assign mark_change   = mark_in_range && (rd_word[mark_pos] != mark_want);

  always_comb begin
    map_req         = '0;
    map_req.wr_addr = mark_addr;
    map_req.wr_data = mark_want ? (rd_word | mark_mask) : (rd_word & ~mark_mask);
    case (state_q)
      StIdle: begin
        if (accept) begin
          map_req.rd_en   = (req_i.action == ActFind) || (req_i.action == ActUse) ||
                            (req_i.action == ActFree);
          map_req.rd_addr = (req_i.action == ActFind) ? '0 :
                            AddrW'(req_i.block_index >> BitW);
        end
      end
      StScan: begin
        if (!scan_hit && !scan_last) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = addr_q + AddrW'(1);
        end
      end
      StMark: begin
        map_req.wr_en = mark_change;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= TotalReset;
      rsp_valid_q <= 1'b0;
      addr_q      <= '0;
      req_q       <= '0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            req_q  <= req_i;
            addr_q <= '0;
            case (req_i.action)
              ActFind: state_q <= StScan;
              ActUse, ActFree: state_q <= StMark;
              default: begin
                // unused action: empty result right away
                rsp_valid_q <= 1'b1;
                rsp_q       <= '0;
              end
            endcase
          end
        end
        StScan: begin
          if (scan_hit) begin
            rsp_valid_q       <= 1'b1;
            rsp_q.found_index <= BlkW'(found_full);
            rsp_q.status      <= (32'(found_full) >= 32'(total_q));
            rsp_q.bit_changed <= 1'b0;
            state_q           <= StIdle;
          end else if (scan_last) begin
            rsp_valid_q <= 1'b1;
            rsp_q       <= '{found_index: '0, status: 1'b1, bit_changed: 1'b0};
            state_q     <= StIdle;
          end else begin
            addr_q <= addr_q + AddrW'(1);
          end
        end
        StMark: begin
          rsp_valid_q <= 1'b1;
          rsp_q       <= '{found_index: '0, status: 1'b0, bit_changed: mark_change};
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `BBA_ASSERT(a_find_goes_busy, accept && (req_i.action == ActFind) |=> busy)
  `BBA_ASSERT(a_write_only_in_mark, map_req.wr_en |-> (state_q == StMark))
  `BBA_ASSERT_MSG(a_rsp_leaves_idle, rsp_valid_o |-> !busy, "result shown while busy")
  `BBA_ASSERT_MSG(a_mark_no_status, rsp_valid_o && rsp_o.bit_changed |-> !rsp_o.status,
                  "mark result with status set")

endmodule

// ===== hdl/bba_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bba_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bba_map.sv =====
// used/free bitmap store: word ram plus per-word valid bits cleared at reset
// depends on bba_pkg and bba_ram
module bba_map (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bba_pkg::map_req_t                req_i,
  output logic [bba_pkg::WordBits-1:0]     rd_word_o
);
  import bba_pkg::*;

  logic [MapWords-1:0] valid_q;
  logic                rd_vld_q;
  logic [WordBits-1:0] ram_rdata;

  bba_ram #(
    .Width(WordBits),
    .Depth(MapWords)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (req_i.rd_en),
    .rd_addr_i(req_i.rd_addr),
    .rd_data_o(ram_rdata),
    .wr_en_i  (req_i.wr_en),
    .wr_addr_i(req_i.wr_addr),
    .wr_data_i(req_i.wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // a word never written reads as all free
  assign rd_word_o = ram_rdata & {WordBits{rd_vld_q}};

endmodule

// ===== test/bitmap_block_allocator_core_test.sv =====
// self-checking testbench for the first-fit bitmap block allocator core
// depends on bba_pkg and bitmap_block_allocator_core; predicts every response itself
`timescale 1ns / 1ps
module bitmap_block_allocator_core_test;
  import bba_pkg::*;

  localparam logic [1:0] ActNone   = 2'd3;
  localparam int         FirstFree = 2;
  localparam int         TailWait  = MapWords + 16;
  localparam int         IdleLimit = 2000;
  localparam int         RandPhases = 16;
  localparam int         PhaseItems = 122;

  typedef struct {
    req_t req;
    bit   take_found;  // block_index comes from the latest find
  } alloc_item_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  req_t            req_i = '0;
  logic            rsp_valid_o;
  rsp_t            rsp_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [TotW-1:0] cfg_data_i = '0;

  bitmap_block_allocator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  logic [MapBits-1:0] used_map = '0;
  logic [TotW-1:0]    block_limit = TotalReset;
  logic [BlkW-1:0]    last_found = '0;

  alloc_item_t req_queue[$];
  rsp_t        due_rsps[$];
  logic        took_item = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          n_items = 0;
  int          n_finds = 0;
  int          n_full = 0;
  int          n_changed = 0;
  int          n_cfg = 0;
  rsp_t        predicted;
  rsp_t        oldest;
  alloc_item_t item;
  req_t        word;

  function automatic rsp_t apply_to_map(req_t r);
    rsp_t o;
    int   hit;
    bit   want;
    o = '0;
    hit = -1;
    case (r.action)
      ActFind: begin
        for (int i = MapBits - 1; i >= FirstFree; i--) begin
          if (!used_map[i]) hit = i;
        end
        if (hit < 0) begin
          o.status = 1'b1;
        end else begin
          o.found_index = hit[BlkW-1:0];
          o.status = (hit >= int'(block_limit));
        end
      end
      ActUse, ActFree: begin
        want = (r.action == ActUse);
        if (used_map[r.block_index] != want) begin
          used_map[r.block_index] = want;
          o.bit_changed = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 40);
    return $urandom_range(41, 140);
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (gap_left > 0 || req_queue.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        item = req_queue.pop_front();
        word = item.req;
        if (item.take_found) word.block_index = last_found;
        start <= 1'b1;
        req_i <= word;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = pick_gap();
        end
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (due_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp_o);
          errors++;
        end else begin
          oldest = due_rsps.pop_front();
          if (rsp_o.found_index !== oldest.found_index) begin
            $error("found_index: expected %0d, got %0d", oldest.found_index, rsp_o.found_index);
            errors++;
          end
          if (rsp_o.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.bit_changed !== oldest.bit_changed) begin
            $error("bit_changed: expected %0d, got %0d", oldest.bit_changed, rsp_o.bit_changed);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_to_map(req_i);
        due_rsps.push_back(predicted);
        n_items++;
        if (predicted.bit_changed) n_changed++;
        if (req_i.action == ActFind) begin
          last_found = predicted.found_index;
          n_finds++;
          if (predicted.status) n_full++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        block_limit = cfg_data_i;
        n_cfg++;
      end
      if (rsp_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    took_item <= rst_ni && start && !busy;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] act, int idx, bit take_found = 1'b0);
    alloc_item_t it;
    it.req.action = act;
    it.req.block_index = idx[BlkW-1:0];
    it.take_found = take_found;
    req_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (!(req_queue.size() == 0 && !start && due_rsps.size() == 0)) @(posedge clk_i);
  endtask

  task automatic write_limit(int value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[TotW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int lim;
    int hi;
    int r;
    int cnt;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reserved blocks, repeated marks, top of map, unused code
    push_req(ActFind, 0);
    push_req(ActUse, 0);
    push_req(ActUse, 0);
    push_req(ActUse, 1);
    push_req(ActFind, 0);
    push_req(ActUse, 2);
    push_req(ActFind, 0);
    push_req(ActFree, 2);
    push_req(ActFree, 2);
    push_req(ActFind, 'hfff);
    push_req(ActUse, 'hfff);
    push_req(ActFree, 'hfff);
    push_req(ActUse, 2048);
    push_req(ActNone, 'hfff);
    push_req(ActNone, 0);
    push_req(ActFree, 0);
    push_req(ActFree, 1);
    write_limit(0);
    push_req(ActFind, 0);
    write_limit(2);
    push_req(ActFind, 0);
    write_limit(3);
    push_req(ActFind, 0);
    write_limit(8191);
    push_req(ActFind, 0);

    // random: mostly allocate pairs (find then use the found block) plus noise
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin
          r = $urandom_range(0, 4);
          lim = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 4095 : (r == 3) ? 4096 : 8191;
        end
        1: lim = int'(last_found);
        2: lim = int'(last_found) + 1;
        default: lim = $urandom_range(0, 8191);
      endcase
      write_limit(lim);
      cnt = 0;
      while (cnt < PhaseItems) begin
        hi = int'(last_found) + 64;
        if (hi > MapBits - 1) hi = MapBits - 1;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          push_req(ActFind, $urandom_range(0, MapBits - 1));
          push_req(ActUse, 0, 1'b1);
          cnt += 2;
        end else begin
          if (r < 60) push_req(ActFree, $urandom_range(0, hi));
          else if (r < 70) push_req(ActUse, $urandom_range(0, hi));
          else if (r < 80) push_req(ActFind, $urandom_range(0, MapBits - 1));
          else if (r < 90) push_req(2'($urandom_range(1, 2)), $urandom_range(0, MapBits - 1));
          else if (r < 95) push_req(ActNone, $urandom_range(0, MapBits - 1));
          else push_req(ActFree, 0, 1'b1);
          cnt++;
        end
      end
    end

    // back to the reset limit
    write_limit(4096);
    push_req(ActFind, 0);
    push_req(ActFree, 2);
    push_req(ActFind, 0);

    wait_drained();
    repeat (TailWait) @(posedge clk_i);
    $display("covered %0d requests: %0d finds (%0d without space), %0d bit changes",
             n_items, n_finds, n_full, n_changed);
    $display("total_blocks written %0d times, extremes 0 and 8191 included", n_cfg);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_map.sv
hdl/bitmap_block_allocator_core.sv
test/bitmap_block_allocator_core_test.sv
